>>> rtl/rtr_pkg.sv
`default_nettype none

package rtr_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 8;
  localparam int TOTAL_W = 9;

  // function codes of an input item
  localparam logic [1:0] FN_WR_NODE  = 2'd0;
  localparam logic [1:0] FN_WR_CHILD = 2'd1;
  localparam logic [1:0] FN_SEARCH   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
  } box_t;

  localparam int BOX_W = 4 * COORD_W;

endpackage

`default_nettype wire

>>> rtl/rtr_ram.sv
`default_nettype none

module rtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rtr_overlap.sv
`default_nettype none

module rtr_overlap
  import rtr_pkg::*;
(
  input  wire box_t node_box,
  input  wire box_t query_box,
  output logic      hit
);

  // closed on every edge
  assign hit = (node_box.min_x <= query_box.max_x) &&
               (node_box.max_x >= query_box.min_x) &&
               (node_box.min_y <= query_box.max_y) &&
               (node_box.max_y >= query_box.min_y);

endmodule

`default_nettype wire

>>> rtl/rtree_range_search.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid/cfg_ready    cfg_root_index
// in       in         in_valid/in_ready      in_func .. in_child_present
// out      out        out_valid/out_ready    out_match_valid .. out_last
//
// A search is accepted, then pops nodes from the stack in turn (pop, node read, check), visits
// each child slot of a popped inner node (slot read, then a box read and check when the slot
// holds a child in the store), stops when the stack is empty or the pop limit is reached, and
// sends the summary; the single node store read port and the shared overlap compare set the pace.
// After reset a clearing pass over all 2**ceil(log2(NODE_COUNT)) *
// 2**ceil(log2(CHILDREN_PER_NODE)) child store entries (2048 by default) runs with in_ready low;
// cfg is always ready. A stalled out channel holds the walk at the next result.

module rtree_range_search
  import rtr_pkg::*;
#(
  parameter int NODE_COUNT        = 256,
  parameter int CHILDREN_PER_NODE = 8,
  parameter int STACK_DEPTH       = 64,
  parameter int MAX_REPORTED      = 63
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [IDX_W-1:0]          cfg_root_index,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_func,
  input  wire logic [IDX_W-1:0]          in_node_index,
  input  wire logic                      in_leaf_flag,
  input  wire logic signed [COORD_W-1:0] in_box_min_x,
  input  wire logic signed [COORD_W-1:0] in_box_max_x,
  input  wire logic signed [COORD_W-1:0] in_box_min_y,
  input  wire logic signed [COORD_W-1:0] in_box_max_y,
  input  wire logic [2:0]                in_child_slot,
  input  wire logic [IDX_W-1:0]          in_child_value,
  input  wire logic                      in_child_present,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_match_valid,
  output logic [IDX_W-1:0]               out_match_index,
  output logic [TOTAL_W-1:0]             out_match_total,
  output logic                           out_truncated,
  output logic                           out_last
);

  localparam int NAW    = $clog2(NODE_COUNT);
  localparam int SW     = $clog2(CHILDREN_PER_NODE);
  localparam int CAW    = NAW + SW;
  localparam int NDEPTH = 1 << NAW;
  localparam int CDEPTH = 1 << CAW;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);
  localparam int PW     = $clog2(NODE_COUNT + 1);
  localparam int RW     = $clog2(MAX_REPORTED + 1);
  localparam int NODE_W = 1 + BOX_W;
  localparam int CHLD_W = 1 + IDX_W;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_POP   = 8'b0000_0100,
    S_NODE  = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_CREAD = 8'b0010_0000,
    S_CBOX  = 8'b0100_0000,
    S_SUM   = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CAW-1:0]     clr_r, clr_nxt;
  logic [IDX_W-1:0]   root_r, root_nxt;
  box_t               qbox_r, qbox_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [PW-1:0]      pops_r, pops_nxt;
  logic [RW-1:0]      nres_r, nres_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               trunc_r, trunc_nxt;
  logic [NAW-1:0]     cur_r, cur_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [NAW-1:0]     ci_r, ci_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_mv_r, out_mv_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [TOTAL_W-1:0] out_tot_r, out_tot_nxt;
  logic               out_tr_r, out_tr_nxt;
  logic               out_last_r, out_last_nxt;

  logic               nd_we, nd_re;
  logic [NAW-1:0]     nd_waddr, nd_raddr;
  logic [NODE_W-1:0]  nd_wdata, nd_rdata;
  logic               ch_we, ch_re;
  logic [CAW-1:0]     ch_waddr, ch_raddr;
  logic [CHLD_W-1:0]  ch_wdata, ch_rdata;
  logic               st_we, st_re;
  logic [SAW-1:0]     st_waddr, st_raddr;
  logic [NAW-1:0]     st_wdata, st_rdata;

  box_t               node_box;
  logic               node_leaf;
  logic               hit;
  logic               in_fire;
  logic               out_free;
  logic [SPW-1:0]     sp_dec;
  logic [IDX_W-1:0]   child_idx;
  logic               advance;

  rtr_ram #(.WIDTH(NODE_W), .DEPTH(NDEPTH)) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .re    (nd_re),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  rtr_ram #(.WIDTH(CHLD_W), .DEPTH(CDEPTH)) u_child_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (ch_re),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  rtr_ram #(.WIDTH(NAW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign node_box  = box_t'(nd_rdata[BOX_W-1:0]);
  assign node_leaf = nd_rdata[NODE_W-1];

  rtr_overlap u_overlap (
    .node_box  (node_box),
    .query_box (qbox_r),
    .hit       (hit)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign sp_dec    = sp_r - 1'b1;
  assign child_idx = ch_rdata[IDX_W-1:0];

  assign out_valid       = out_valid_r;
  assign out_match_valid = out_mv_r;
  assign out_match_index = out_idx_r;
  assign out_match_total = out_tot_r;
  assign out_truncated   = out_tr_r;
  assign out_last        = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    root_nxt      = root_r;
    qbox_nxt      = qbox_r;
    sp_nxt        = sp_r;
    pops_nxt      = pops_r;
    nres_nxt      = nres_r;
    total_nxt     = total_r;
    trunc_nxt     = trunc_r;
    cur_nxt       = cur_r;
    slot_nxt      = slot_r;
    ci_nxt        = ci_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mv_nxt    = out_mv_r;
    out_idx_nxt   = out_idx_r;
    out_tot_nxt   = out_tot_r;
    out_tr_nxt    = out_tr_r;
    out_last_nxt  = out_last_r;
    nd_we         = 1'b0;
    nd_waddr      = '0;
    nd_wdata      = '0;
    nd_re         = 1'b0;
    nd_raddr      = '0;
    ch_we         = 1'b0;
    ch_waddr      = '0;
    ch_wdata      = '0;
    ch_re         = 1'b0;
    ch_raddr      = '0;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_wdata      = '0;
    st_re         = 1'b0;
    st_raddr      = '0;
    advance       = 1'b0;

    if (cfg_valid && cfg_ready) begin
      root_nxt = cfg_root_index;
    end

    case (state_r)
      S_CLR: begin
        nd_we    = 1'b1;
        nd_waddr = clr_r[CAW-1:SW];
        ch_we    = 1'b1;
        ch_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_WR_NODE: begin
              if (32'(in_node_index) < NODE_COUNT) begin
                nd_we    = 1'b1;
                nd_waddr = NAW'(in_node_index);
                nd_wdata = {in_leaf_flag, in_box_min_x, in_box_max_x,
                            in_box_min_y, in_box_max_y};
              end
            end
            FN_WR_CHILD: begin
              if ((32'(in_node_index) < NODE_COUNT) &&
                  (32'(in_child_slot) < CHILDREN_PER_NODE)) begin
                ch_we    = 1'b1;
                ch_waddr = {NAW'(in_node_index), SW'(in_child_slot)};
                ch_wdata = in_child_present ? {1'b1, in_child_value} : '0;
              end
            end
            FN_SEARCH: begin
              qbox_nxt  = '{min_x: in_box_min_x, max_x: in_box_max_x,
                            min_y: in_box_min_y, max_y: in_box_max_y};
              sp_nxt    = '0;
              pops_nxt  = '0;
              nres_nxt  = '0;
              total_nxt = '0;
              trunc_nxt = 1'b0;
              if (32'(root_r) < NODE_COUNT) begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = NAW'(root_r);
                sp_nxt   = SPW'(1);
              end
              state_nxt = S_POP;
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_SUM;
        end else if (pops_r == PW'(NODE_COUNT)) begin
          // runaway walk over shared or cyclic links
          trunc_nxt = 1'b1;
          state_nxt = S_SUM;
        end else begin
          pops_nxt  = pops_r + 1'b1;
          sp_nxt    = sp_dec;
          st_re     = 1'b1;
          st_raddr  = sp_dec[SAW-1:0];
          state_nxt = S_NODE;
        end
      end

      S_NODE: begin
        cur_nxt   = st_rdata;
        nd_re     = 1'b1;
        nd_raddr  = st_rdata;
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (node_leaf) begin
          if (!hit) begin
            state_nxt = S_POP;
          end else if (32'(nres_r) < MAX_REPORTED) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_mv_nxt    = 1'b1;
              out_idx_nxt   = IDX_W'(cur_r);
              out_tot_nxt   = '0;
              out_tr_nxt    = 1'b0;
              out_last_nxt  = 1'b0;
              nres_nxt      = nres_r + 1'b1;
              if (total_r != '1) begin
                total_nxt = total_r + 1'b1;
              end
              state_nxt = S_POP;
            end
          end else begin
            // past the report limit: counted only
            trunc_nxt = 1'b1;
            if (total_r != '1) begin
              total_nxt = total_r + 1'b1;
            end
            state_nxt = S_POP;
          end
        end else begin
          slot_nxt  = '0;
          ch_re     = 1'b1;
          ch_raddr  = {cur_r, SW'(0)};
          state_nxt = S_CREAD;
        end
      end

      S_CREAD: begin
        if (ch_rdata[CHLD_W-1] && (32'(child_idx) < NODE_COUNT)) begin
          ci_nxt    = NAW'(child_idx);
          nd_re     = 1'b1;
          nd_raddr  = NAW'(child_idx);
          state_nxt = S_CBOX;
        end else begin
          advance = 1'b1;
        end
      end

      S_CBOX: begin
        if (hit) begin
          if (sp_r < SPW'(STACK_DEPTH)) begin
            st_we    = 1'b1;
            st_waddr = sp_r[SAW-1:0];
            st_wdata = ci_r;
            sp_nxt   = sp_r + 1'b1;
          end else begin
            trunc_nxt = 1'b1;
          end
        end
        advance = 1'b1;
      end

      S_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = 1'b0;
          out_idx_nxt   = '0;
          out_tot_nxt   = total_r;
          out_tr_nxt    = trunc_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next child slot of the current inner node
    if (advance) begin
      if (slot_r == SW'(CHILDREN_PER_NODE - 1)) begin
        state_nxt = S_POP;
      end else begin
        slot_nxt  = slot_r + 1'b1;
        ch_re     = 1'b1;
        ch_raddr  = {cur_r, slot_r + 1'b1};
        state_nxt = S_CREAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      root_r      <= '0;
      sp_r        <= '0;
      pops_r      <= '0;
      nres_r      <= '0;
      total_r     <= '0;
      trunc_r     <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      root_r      <= root_nxt;
      sp_r        <= sp_nxt;
      pops_r      <= pops_nxt;
      nres_r      <= nres_nxt;
      total_r     <= total_nxt;
      trunc_r     <= trunc_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qbox_r     <= qbox_nxt;
    cur_r      <= cur_nxt;
    ci_r       <= ci_nxt;
    out_mv_r   <= out_mv_nxt;
    out_idx_r  <= out_idx_nxt;
    out_tot_r  <= out_tot_nxt;
    out_tr_r   <= out_tr_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import rtr_pkg::*;

  localparam int NODE_COUNT    = 256;
  localparam int CHILDREN      = 8;
  localparam int STACK_DEPTH   = 64;
  localparam int MAX_REPORTED  = 63;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_GAP      = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 30000;
  localparam int COORD_MIN     = -32768;
  localparam int COORD_MAX     = 32767;
  localparam int TOTAL_CAP     = 511;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       func;
    logic [IDX_W-1:0] node;
    logic             leaf;
    box_t             rect;
    logic [2:0]       slot;
    logic [IDX_W-1:0] cval;
    logic             cpres;
  } rtree_item_t;

  typedef struct packed {
    logic               mv;
    logic [IDX_W-1:0]   idx;
    logic [TOTAL_W-1:0] total;
    logic               trunc;
    logic               last;
  } leaf_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_root_index = '0;
  logic in_valid = 1'b0;
  logic [1:0] in_func = FN_WR_NODE;
  logic [IDX_W-1:0] in_node_index = '0;
  logic in_leaf_flag = 1'b0;
  logic signed [COORD_W-1:0] in_box_min_x = '0;
  logic signed [COORD_W-1:0] in_box_max_x = '0;
  logic signed [COORD_W-1:0] in_box_min_y = '0;
  logic signed [COORD_W-1:0] in_box_max_y = '0;
  logic [2:0] in_child_slot = '0;
  logic [IDX_W-1:0] in_child_value = '0;
  logic in_child_present = 1'b0;
  logic out_ready = 1'b0;

  logic cfg_ready, in_ready, out_valid;
  logic out_match_valid, out_truncated, out_last;
  logic [IDX_W-1:0] out_match_index;
  logic [TOTAL_W-1:0] out_match_total;

  // shadow of the tree, owned by the monitor
  box_t               node_box   [NODE_COUNT];
  logic               node_leaf  [NODE_COUNT];
  logic [IDX_W:0]     node_child [NODE_COUNT][CHILDREN];
  logic [IDX_W-1:0]   root_shadow;
  leaf_report_t       pending_reports[$];
  int                 in_count = 0;
  int                 cfg_count = 0;
  int                 mismatches = 0;

  // stimulus side
  bit box_loaded [NODE_COUNT];
  int send_idle = 27;
  int recv_idle = 69;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  rtree_range_search #(
    .NODE_COUNT       (NODE_COUNT),
    .CHILDREN_PER_NODE(CHILDREN),
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_REPORTED     (MAX_REPORTED)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_root_index  (cfg_root_index),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_node_index   (in_node_index),
    .in_leaf_flag    (in_leaf_flag),
    .in_box_min_x    (in_box_min_x),
    .in_box_max_x    (in_box_max_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_max_y    (in_box_max_y),
    .in_child_slot   (in_child_slot),
    .in_child_value  (in_child_value),
    .in_child_present(in_child_present),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_valid (out_match_valid),
    .out_match_index (out_match_index),
    .out_match_total (out_match_total),
    .out_truncated   (out_truncated),
    .out_last        (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // closed on every edge
  function automatic bit boxes_touch(box_t n, box_t q);
    return n.min_x <= q.max_x && n.max_x >= q.min_x &&
           n.min_y <= q.max_y && n.max_y >= q.min_y;
  endfunction

  // depth-first walk from the root, queueing the leaf reports and the summary
  function automatic void walk_query(box_t q);
    logic [IDX_W-1:0] walk [STACK_DEPTH];
    logic [IDX_W-1:0] cur;
    logic [IDX_W:0]   child;
    int depth, pops, found, reported;
    bit capped, stopped;
    depth = 1;
    walk[0] = root_shadow;
    pops = 0;
    found = 0;
    reported = 0;
    capped = 1'b0;
    stopped = 1'b0;
    while (depth > 0 && !stopped) begin
      if (pops >= NODE_COUNT) begin
        // runaway walk over shared or cyclic links
        capped = 1'b1;
        stopped = 1'b1;
      end else begin
        pops++;
        depth--;
        cur = walk[depth];
        if (node_leaf[cur]) begin
          if (boxes_touch(node_box[cur], q)) begin
            if (found < TOTAL_CAP) found++;
            if (reported < MAX_REPORTED) begin
              pending_reports.push_back({1'b1, cur, TOTAL_W'(0), 1'b0, 1'b0});
              reported++;
            end else begin
              capped = 1'b1;
            end
          end
        end else begin
          for (int s = 0; s < CHILDREN; s++) begin
            child = node_child[cur][s];
            if (child[IDX_W] && boxes_touch(node_box[child[IDX_W-1:0]], q)) begin
              if (depth < STACK_DEPTH) begin
                walk[depth] = child[IDX_W-1:0];
                depth++;
              end else begin
                capped = 1'b1;
              end
            end
          end
        end
      end
    end
    pending_reports.push_back({1'b0, IDX_W'(0), TOTAL_W'(found), capped, 1'b1});
  endfunction

  always @(posedge clk) begin : monitor
    leaf_report_t got, want;
    if (!rst_n) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        node_leaf[n] = 1'b0;
        for (int s = 0; s < CHILDREN; s++) node_child[n][s] = '0;
      end
      root_shadow = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        root_shadow = cfg_root_index;
        cfg_count++;
      end
      if (in_valid && in_ready) begin
        case (in_func)
          FN_WR_NODE: begin
            node_box[in_node_index] = {in_box_min_x, in_box_max_x, in_box_min_y, in_box_max_y};
            node_leaf[in_node_index] = in_leaf_flag;
          end
          FN_WR_CHILD: begin
            node_child[in_node_index][in_child_slot] =
                in_child_present ? {1'b1, in_child_value} : '0;
          end
          FN_SEARCH: begin
            walk_query({in_box_min_x, in_box_max_x, in_box_min_y, in_box_max_y});
          end
          default: ;
        endcase
        in_count++;
      end
      if (out_valid && out_ready) begin
        got = {out_match_valid, out_match_index, out_match_total, out_truncated, out_last};
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected item valid=%0b index=%0d total=%0d trunc=%0b last=%0b",
                   $time, got.mv, got.idx, got.total, got.trunc, got.last);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            // fields: valid/index/total/trunc/last
            $display("%0t: expected %0b/%0d/%0d/%0b/%0b actual %0b/%0d/%0d/%0b/%0b",
                     $time, want.mv, want.idx, want.total, want.trunc, want.last,
                     got.mv, got.idx, got.total, got.trunc, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_armed != hold_taken) begin
      hold_taken = hold_armed;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic box_t mk_box(int x0, int x1, int y0, int y1);
    box_t b;
    b.min_x = COORD_W'(x0);
    b.max_x = COORD_W'(x1);
    b.min_y = COORD_W'(y0);
    b.max_y = COORD_W'(y1);
    return b;
  endfunction

  function automatic box_t random_box();
    int cx, cy, wx, wy, pick;
    pick = $urandom_range(99);
    cx = int'($urandom_range(4000)) - 2000;
    cy = int'($urandom_range(4000)) - 2000;
    wx = $urandom_range(1500);
    wy = $urandom_range(1500);
    if (pick < 8) return mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    if (pick < 16) return {$urandom, $urandom};
    if (pick < 22) return mk_box(cx + wx + 1, cx, cy - wy, cy + wy);
    if (pick < 28) return mk_box(cx, cx, cy, cy);
    return mk_box(cx - wx, cx + wx, cy - wy, cy + wy);
  endfunction

  function automatic rtree_item_t node_write(logic [IDX_W-1:0] node, logic leaf, box_t rect);
    rtree_item_t it;
    it.func = FN_WR_NODE;
    it.node = node;
    it.leaf = leaf;
    it.rect = rect;
    it.slot = 3'($urandom);
    it.cval = IDX_W'($urandom);
    it.cpres = 1'($urandom);
    return it;
  endfunction

  function automatic rtree_item_t child_write(logic [IDX_W-1:0] node, logic [2:0] slot,
                                              logic [IDX_W-1:0] value, logic present);
    rtree_item_t it;
    it.func = FN_WR_CHILD;
    it.node = node;
    it.leaf = 1'($urandom);
    it.rect = {$urandom, $urandom};
    it.slot = slot;
    it.cval = value;
    it.cpres = present;
    return it;
  endfunction

  function automatic rtree_item_t search_item(box_t rect);
    rtree_item_t it;
    it.func = FN_SEARCH;
    it.node = IDX_W'($urandom);
    it.leaf = 1'($urandom);
    it.rect = rect;
    it.slot = 3'($urandom);
    it.cval = IDX_W'($urandom);
    it.cpres = 1'($urandom);
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    logic [IDX_W-1:0] n;
    n = IDX_W'($urandom);
    while (!box_loaded[n]) n = IDX_W'($urandom);
    return n;
  endfunction

  // entered and left on a falling edge; valid stays high on return
  task automatic send_item(input rtree_item_t it);
    int target;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_func <= it.func;
    in_node_index <= it.node;
    in_leaf_flag <= it.leaf;
    in_box_min_x <= it.rect.min_x;
    in_box_max_x <= it.rect.max_x;
    in_box_min_y <= it.rect.min_y;
    in_box_max_y <= it.rect.max_y;
    in_child_slot <= it.slot;
    in_child_value <= it.cval;
    in_child_present <= it.cpres;
    in_valid <= 1'b1;
    target = in_count + 1;
    do @(negedge clk); while (in_count < target);
    if (it.func == FN_WR_NODE) box_loaded[it.node] = 1'b1;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] root);
    int target;
    wait_idle();
    cfg_root_index <= root;
    cfg_valid <= 1'b1;
    target = cfg_count + 1;
    do @(negedge clk); while (cfg_count < target);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // root 0 straight after reset: inner node with no children
  task automatic test_empty_tree();
    send_item(search_item(mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)));
  endtask

  task automatic test_leaf_root();
    write_root(8'd0);
    send_item(node_write(8'd0, 1'b1, mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)));
    send_item(search_item(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)));
    send_item(search_item(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN)));
    // min above max still matches the full-range leaf
    send_item(search_item(mk_box(5, 4, COORD_MIN, COORD_MAX)));
    send_item(node_write(8'd0, 1'b1, mk_box(0, 10, 0, 10)));
    // corners touching count as overlap
    send_item(search_item(mk_box(10, 20, -5, 0)));
    send_item(search_item(mk_box(11, 20, 0, 10)));
    send_item(search_item(mk_box(-20, -1, 0, 10)));
  endtask

  task automatic test_inner_order();
    send_item(node_write(8'd1, 1'b0, mk_box(-100, 100, -100, 100)));
    send_item(node_write(8'd2, 1'b1, mk_box(0, 5, 0, 5)));
    send_item(node_write(8'd3, 1'b1, mk_box(50, 60, 50, 60)));
    send_item(child_write(8'd1, 3'd0, 8'd2, 1'b1));
    send_item(child_write(8'd1, 3'd7, 8'd3, 1'b1));
    write_root(8'd1);
    send_item(search_item(mk_box(-100, 100, -100, 100)));
    send_item(child_write(8'd1, 3'd7, 8'd3, 1'b0));
    send_item(search_item(mk_box(-100, 100, -100, 100)));
  endtask

  task automatic test_unused_func();
    rtree_item_t it;
    it = search_item(random_box());
    it.func = FN_UNUSED;
    send_item(it);
    send_item(search_item(mk_box(-100, 100, -100, 100)));
  endtask

  // two self links and a leaf: stack grows, results cap, walk runs away
  task automatic test_runaway_walk();
    send_item(node_write(8'd255, 1'b0, mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)));
    send_item(child_write(8'd255, 3'd0, 8'd255, 1'b1));
    send_item(child_write(8'd255, 3'd1, 8'd255, 1'b1));
    send_item(child_write(8'd255, 3'd2, 8'd2, 1'b1));
    write_root(8'd255);
    send_item(search_item(mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)));
  endtask

  task automatic test_output_stall();
    send_idle = 0;
    hold_armed = ~hold_armed;
    repeat (4) send_item(search_item(mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)));
  endtask

  task automatic test_random_trees(input int budget);
    logic [IDX_W-1:0] node_pool[$];
    logic [IDX_W-1:0] members[$];
    logic [IDX_W-1:0] swap;
    bit inner[$];
    int sent, n, parent, pick, pool_pos, j;
    rtree_item_t it;
    for (int k = 4; k < 255; k++) node_pool.push_back(IDX_W'(k));
    for (int k = node_pool.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      swap = node_pool[k];
      node_pool[k] = node_pool[j];
      node_pool[j] = swap;
    end
    pool_pos = 0;
    sent = 0;
    while (sent < budget) begin
      case (sent * 3 / budget)
        0: begin
          send_idle = 27;
          recv_idle = 69;
        end
        1: begin
          send_idle = 69;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      n = $urandom_range(12, 2);
      members.delete();
      inner.delete();
      for (int i = 0; i < n; i++) begin
        members.push_back(node_pool[pool_pos]);
        pool_pos = (pool_pos + 1) % node_pool.size();
        inner.push_back(i == 0 ? ($urandom_range(99) < 90) : ($urandom_range(99) < 35));
        send_item(node_write(members[i], !inner[i], random_box()));
        sent++;
      end
      for (int i = 1; i < n; i++) begin
        parent = $urandom_range(i - 1);
        while (parent >= 0 && !inner[parent]) parent--;
        if (parent >= 0) begin
          send_item(child_write(members[parent], 3'($urandom), members[i], 1'b1));
          sent++;
        end
      end
      // malformed extras: shared or cyclic link, cleared slot, unused code
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(child_write(members[$urandom_range(n - 1)], 3'($urandom), pick_loaded(),
                              1'b1));
        sent++;
      end else if (pick < 20) begin
        send_item(child_write(members[$urandom_range(n - 1)], 3'($urandom),
                              IDX_W'($urandom), 1'b0));
        sent++;
      end else if (pick < 25) begin
        it = search_item(random_box());
        it.func = FN_UNUSED;
        send_item(it);
      end
      write_root($urandom_range(99) < 90 ? members[0] : pick_loaded());
      repeat ($urandom_range(5, 2)) begin
        send_item(search_item(random_box()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_tree();
    test_leaf_root();
    test_inner_order();
    test_unused_func();
    test_runaway_walk();
    test_output_stall();
    test_random_trees(250);
    wait_idle();
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
